// ===== rtl/wequ_pkg.sv =====
// shared types, constants and elaboration-time helpers of the error queue dither
package wequ_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int SHADE_W = 9;
    localparam int ERR_W   = 9;
    localparam int WGT_W   = 5;

    // quantizer constants
    localparam int QNT_DIV  = 510;
    localparam int QNT_BIAS = 255;
    localparam int SHADE_MIN = 2;
    localparam int WGT_SHIFT = 4;

    // serial divider geometry
    localparam int DIV_NUM_W = 18;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_Q_W   = 9;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_QNT,
        ST_DIV1,
        ST_REC,
        ST_DIV2,
        ST_DONE
    } t_state;

    // commands to the error queue
    typedef struct packed {
        logic                    start;
        logic                    push;
        logic signed [ERR_W-1:0] err;
    } t_acc_ctl;

    // width of the weighted sum for a given queue depth
    function automatic int sum_width(int depth);
        return ERR_W + WGT_W + $clog2(depth);
    endfunction

    // round(16^(i/d)): largest k with (2k-1)^d <= 2^(d + 4i)
    function automatic int weight_of(int i, int d);
        logic [255:0] b;
        logic [255:0] lim;
        int           k;
        bit           stop;
        k    = 1;
        stop = 1'b0;
        lim  = 256'd1 << (d + WGT_SHIFT * i);
        for (int c = 2; c <= (1 << WGT_SHIFT); c++) begin
            if (!stop) begin
                b = 256'd1;
                for (int n = 0; n < d; n++) begin
                    b = b * 256'(2 * c - 1);
                end
                if (b <= lim) begin
                    k = c;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/wequ_ifs.sv =====
// valid/ready stream interfaces for the pixel input and output beats
interface wequ_in_if;
    logic                        valid;
    logic                        ready;
    logic [wequ_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface wequ_out_if;
    logic                        valid;
    logic                        ready;
    logic [wequ_pkg::PIX_W-1:0]  pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== rtl/weighted_error_queue_dither_unit.sv =====
// top level of the error queue dither: sequencer, quantizer and output register
// Usage:
// - i_pix carries one 8-bit pixel per beat, already in curve order; o_pix
//   carries one quantized pixel per input beat, in the same order.
// - i_cfg_we / i_cfg_wdata write the shade count; write it only while idle.
//   Values below two act as two.
// - One pixel at a time: ready is high only between items. The weighted
//   sum walks the queue one entry per cycle; the two level divisions run
//   bit-serially on one shared divider, and the first of them is skipped
//   when the level saturates at black or at full scale.
// - A finished pixel sits in an output register; the next input beat is
//   taken while it waits. If the receiver still stalls when the following
//   pixel is done, that pixel waits and the error queue is not updated.
// - Synchronous reset clears the error queue, sets the shade count to two
//   and empties the output register.
module weighted_error_queue_dither_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wequ_pkg::SHADE_W-1:0]       i_cfg_wdata,
    wequ_in_if.sink                            i_pix,
    wequ_out_if.source                         o_pix
);
    localparam int SUM_W   = wequ_pkg::sum_width(QUEUE_DEPTH);
    localparam int V_W     = SUM_W + 1;
    localparam int PROD_W  = V_W + wequ_pkg::SHADE_W + 1;
    localparam int N_W     = PROD_W + 2;
    localparam int PIX_W   = wequ_pkg::PIX_W;
    localparam int SHADE_W = wequ_pkg::SHADE_W;
    localparam int NUM_W   = wequ_pkg::DIV_NUM_W;
    localparam int DEN_W   = wequ_pkg::DIV_DEN_W;
    localparam int Q_W     = wequ_pkg::DIV_Q_W;
    localparam int SHIFT   = wequ_pkg::WGT_SHIFT;

    wequ_pkg::t_state          r_state, n_state;
    logic [SHADE_W-1:0]        r_shade, n_shade;
    logic [PIX_W-1:0]          r_pix, n_pix;
    logic [SHADE_W-1:0]        r_sm1, n_sm1;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic [Q_W-1:0]            r_q, n_q;
    logic [PIX_W-1:0]          r_opix, n_opix;
    logic                      r_ovalid, n_ovalid;

    logic                      in_ready;
    wequ_pkg::t_acc_ctl        acc_ctl;
    logic                      acc_done;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [SUM_W-1:0]   s_bias;
    logic signed [SUM_W-1:0]   s_div;
    logic signed [V_W-1:0]     v;
    logic signed [N_W-1:0]     n_val;
    logic [SHADE_W:0]          sp;
    logic [NUM_W:0]            sp_x510;
    logic signed [N_W-1:0]     q_lim;
    logic [NUM_W-1:0]          rec_num;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic [Q_W-1:0]            div_quo;

    wequ_acc #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .o_done  (acc_done),
        .o_sum   (acc_sum)
    );

    wequ_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sum / 16 truncated toward zero, then added to the pixel
    assign s_bias = acc_sum + $signed({{(SUM_W - SHIFT){1'b0}}, {SHIFT{acc_sum[SUM_W-1]}}});
    assign s_div  = s_bias >>> SHIFT;
    assign v      = V_W'(s_div) + V_W'($signed({1'b0, r_pix}));

    // 2 * v * (S-1) + 255 and the saturation limit 510 * S
    assign n_val   = (N_W'(r_prod) <<< 1) + N_W'(wequ_pkg::QNT_BIAS);
    assign sp      = {1'b0, r_sm1} + (SHADE_W + 1)'(1);
    assign sp_x510 = {sp, 9'b0} - {8'b0, sp, 1'b0};
    assign q_lim   = N_W'($signed({1'b0, sp_x510}));

    // 510 * q + (S-1), the numerator of the reconstruction
    assign rec_num = {r_q, 9'b0} - {8'b0, r_q, 1'b0} + {9'b0, r_sm1};

    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_shade   = i_cfg_we ? i_cfg_wdata : r_shade;
        n_pix     = r_pix;
        n_sm1     = r_sm1;
        n_prod    = r_prod;
        n_q       = r_q;
        n_opix    = r_opix;
        n_ovalid  = r_ovalid && !o_pix.ready;
        in_ready  = 1'b0;
        acc_ctl   = '{start: 1'b0, push: 1'b0, err: '0};
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            wequ_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_pix.valid) begin
                    n_pix = i_pix.pixel_in;
                    n_sm1 = (r_shade < SHADE_W'(wequ_pkg::SHADE_MIN)) ?
                            SHADE_W'(1) : r_shade - SHADE_W'(1);
                    acc_ctl.start = 1'b1;
                    n_state = wequ_pkg::ST_SUM;
                end
            end
            wequ_pkg::ST_SUM: begin
                if (acc_done) begin
                    n_state = wequ_pkg::ST_MUL;
                end
            end
            wequ_pkg::ST_MUL: begin
                n_prod  = PROD_W'(v) * PROD_W'($signed({1'b0, r_sm1}));
                n_state = wequ_pkg::ST_QNT;
            end
            wequ_pkg::ST_QNT: begin
                if (n_val < 0) begin
                    n_q     = '0;
                    n_state = wequ_pkg::ST_REC;
                end else if (n_val >= q_lim) begin
                    n_q     = r_sm1;
                    n_state = wequ_pkg::ST_REC;
                end else begin
                    div_start = 1'b1;
                    div_num   = n_val[NUM_W-1:0];
                    div_den   = DEN_W'(wequ_pkg::QNT_DIV);
                    n_state   = wequ_pkg::ST_DIV1;
                end
            end
            wequ_pkg::ST_DIV1: begin
                if (div_done) begin
                    n_q     = div_quo;
                    n_state = wequ_pkg::ST_REC;
                end
            end
            wequ_pkg::ST_REC: begin
                div_start = 1'b1;
                div_num   = rec_num;
                div_den   = {r_sm1, 1'b0};
                n_state   = wequ_pkg::ST_DIV2;
            end
            wequ_pkg::ST_DIV2: begin
                if (div_done) begin
                    n_state = wequ_pkg::ST_DONE;
                end
            end
            wequ_pkg::ST_DONE: begin
                if (!r_ovalid || o_pix.ready) begin
                    n_opix        = div_quo[PIX_W-1:0];
                    n_ovalid      = 1'b1;
                    acc_ctl.push  = 1'b1;
                    acc_ctl.err   = $signed({1'b0, r_pix}) -
                                    $signed({1'b0, div_quo[PIX_W-1:0]});
                    n_state       = wequ_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wequ_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wequ_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shade  <= SHADE_W'(wequ_pkg::SHADE_MIN);
            r_ovalid <= 1'b0;
        end else begin
            r_shade  <= n_shade;
            r_ovalid <= n_ovalid;
        end
    end

    // per-item payload registers
    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_sm1  <= n_sm1;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_opix <= n_opix;
    end

    assign i_pix.ready     = in_ready;
    assign o_pix.valid     = r_ovalid;
    assign o_pix.pixel_out = r_opix;

`ifndef SYNTH
    a_accept_starts_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_state == wequ_pkg::ST_SUM))
        else $error("accepted beat did not start the weighted sum");
    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == wequ_pkg::ST_DIV1 || r_state == wequ_pkg::ST_DIV2))
        else $error("divider finished outside a division step");
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wequ_pkg::ST_REC) |-> (r_q <= r_sm1))
        else $error("quantized level above the top shade");
    a_push_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_ctl.push |=> r_ovalid)
        else $error("error queue updated without an output beat");
`endif

endmodule

// ===== rtl/wequ_acc.sv =====
// error queue shift register with a serial weighted accumulator
module wequ_acc #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wequ_pkg::t_acc_ctl                     i_ctl,
    output logic                                   o_done,
    output logic signed [wequ_pkg::sum_width(QUEUE_DEPTH)-1:0] o_sum
);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = wequ_pkg::sum_width(QUEUE_DEPTH);
    localparam int ERR_W = wequ_pkg::ERR_W;
    localparam int WGT_W = wequ_pkg::WGT_W;

    logic signed [ERR_W-1:0]   r_que [QUEUE_DEPTH];
    logic signed [ERR_W-1:0]   n_que [QUEUE_DEPTH];
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [WGT_W-1:0]          w_tab [QUEUE_DEPTH];
    logic signed [ERR_W+WGT_W:0] prod;
    logic                      last;

    // weight table, oldest entry first
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_wtab
        assign w_tab[g] = WGT_W'(wequ_pkg::weight_of(g, QUEUE_DEPTH - 1));
    end

    assign prod = r_que[0] * $signed({1'b0, w_tab[r_idx]});
    assign last = (r_idx == IDX_W'(QUEUE_DEPTH - 1));

    // rotate through the queue one entry per cycle, or shift in a new error
    always_comb begin
        n_idx  = r_idx;
        n_busy = r_busy;
        n_done = 1'b0;
        n_sum  = r_sum;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_que[i] = r_que[i];
        end
        if (i_ctl.start) begin
            n_idx  = '0;
            n_busy = 1'b1;
            n_sum  = '0;
        end else if (r_busy) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_que[i] = r_que[i + 1];
            end
            n_que[QUEUE_DEPTH - 1] = r_que[0];
            n_sum = r_sum + SUM_W'(prod);
            n_idx = r_idx + IDX_W'(1);
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_ctl.push) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_que[i] = r_que[i + 1];
            end
            n_que[QUEUE_DEPTH - 1] = i_ctl.err;
        end
    end

    // queue and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_que[i] <= '0;
            end
            r_idx  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_que[i] <= n_que[i];
            end
            r_idx  <= n_idx;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // running sum
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

`ifndef SYNTH
    a_done_ends_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("weighted sum reported while the pass still runs");
`endif

endmodule

// ===== rtl/wequ_div.sv =====
// restoring divider, one quotient bit per cycle
module wequ_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [wequ_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [wequ_pkg::DIV_DEN_W-1:0]    i_den,
    output logic                              o_done,
    output logic [wequ_pkg::DIV_Q_W-1:0]      o_quo
);
    localparam int NUM_W = wequ_pkg::DIV_NUM_W;
    localparam int DEN_W = wequ_pkg::DIV_DEN_W;
    localparam int Q_W   = wequ_pkg::DIV_Q_W;
    localparam int CNT_W = wequ_pkg::DIV_CNT_W;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DEN_W-1:0]   r_rem, n_rem;
    logic [Q_W-1:0]     r_low, n_low;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [DEN_W:0]     trial;
    logic               ge;

    // partial remainder with the next numerator bit shifted in
    assign trial = {r_rem, r_low[Q_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    // numerator bits leave the top of r_low while quotient bits enter below
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = DEN_W'(i_num[NUM_W-1:Q_W]);
            n_low  = i_num[Q_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_low = {r_low[Q_W-2:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder reached the divisor");
`endif

endmodule

// ===== test/weighted_error_queue_dither_unit_test.sv =====
// self-checking regression of the weighted error queue dither unit
`timescale 1ns / 100ps

module weighted_error_queue_dither_unit_test;

    localparam int PW = wequ_pkg::PIX_W;
    localparam int SW = wequ_pkg::SHADE_W;
    localparam int EW = wequ_pkg::ERR_W;

    localparam int HIST_DEPTH      = 16;
    localparam int DRAIN_CYCLES    = HIST_DEPTH + 30;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_CYCLES     = 300;
    localparam int DIR_ROWS        = 30;

    // error weights, oldest entry first
    localparam int ERR_WEIGHT [HIST_DEPTH] = '{1, 1, 1, 2, 2, 3, 3, 4, 4, 5, 6, 8, 9, 11, 13, 16};

    // one row of the directed part: a shade write or a pixel beat
    typedef struct packed {
        logic          cfg_row;
        logic [SW-1:0] shade;
        logic [PW-1:0] pix;
        logic          known;
        logic [PW-1:0] pix_exp;
    } t_dir_row;

    // expected values typed in only where the error queue is still all zero
    localparam t_dir_row DIR_TAB [0:DIR_ROWS-1] = '{
        '{1'b0, 9'd0,   8'd0,   1'b1, 8'd0},
        '{1'b0, 9'd0,   8'd255, 1'b1, 8'd255},
        '{1'b0, 9'd0,   8'd127, 1'b1, 8'd0},
        '{1'b0, 9'd0,   8'd128, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd0,   1'b0, 8'd0},
        '{1'b1, 9'd256, 8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd255, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd1,   1'b0, 8'd0},
        '{1'b1, 9'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd200, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd60,  1'b0, 8'd0},
        '{1'b1, 9'd1,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd128, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd127, 1'b0, 8'd0},
        '{1'b1, 9'd511, 8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd255, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd77,  1'b0, 8'd0},
        '{1'b1, 9'd257, 8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd254, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd3,   1'b0, 8'd0},
        '{1'b1, 9'd3,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd85,  1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd170, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd255, 1'b0, 8'd0},
        '{1'b1, 9'd16,  8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd0,   1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd255, 1'b0, 8'd0},
        '{1'b0, 9'd0,   8'd100, 1'b0, 8'd0}
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [SW-1:0] i_cfg_wdata;

    wequ_in_if  pix_in ();
    wequ_out_if pix_out ();

    weighted_error_queue_dither_unit #(
        .QUEUE_DEPTH (HIST_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    // predictor state: shade count and error history
    logic [SW-1:0]        shade_reg;
    logic signed [EW-1:0] err_hist [HIST_DEPTH];
    logic [PW-1:0]        expected_pix_q [$];
    logic [PW-1:0]        exp_pix;
    logic [PW-1:0]        last_pix;

    int  fail_cnt      = 0;
    int  cycle_cnt     = 0;
    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    int  hold_left     = 0;
    bit  hold_req      = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // quantize one pixel against the error history, then shift in its error
    function automatic logic [PW-1:0] predict_pixel(input logic [PW-1:0] pix);
        longint p;
        longint acc;
        longint v;
        longint lvl;
        longint num;
        longint lev;
        longint o;
        p   = pix;
        acc = 0;
        lvl = shade_reg;
        if (lvl < 2) begin
            lvl = 2;
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            acc += longint'(ERR_WEIGHT[i]) * longint'(err_hist[i]);
        end
        v   = p + acc / 16;
        num = 2 * v * (lvl - 1) + 255;
        if (num >= 0) begin
            lev = num / 510;
        end else begin
            lev = -((-num + 509) / 510);
        end
        if (lev < 0) begin
            lev = 0;
        end
        if (lev > lvl - 1) begin
            lev = lvl - 1;
        end
        o = (510 * lev + lvl - 1) / (2 * (lvl - 1));
        if (o > 255) begin
            o = 255;
        end
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            err_hist[i] = err_hist[i + 1];
        end
        err_hist[HIST_DEPTH - 1] = EW'(p - o);
        return PW'(o);
    endfunction

    // random pixel: mostly uniform, some extremes, some smooth runs
    function automatic logic [PW-1:0] next_pixel();
        int sel;
        int t;
        sel = $urandom_range(99);
        if (sel < 60) begin
            t = $urandom_range(255);
        end else if (sel < 75) begin
            t = $urandom_range(1) ? 255 : 0;
        end else begin
            t = int'(last_pix) + int'($urandom_range(8)) - 4;
            if (t < 0) begin
                t = 0;
            end
            if (t > 255) begin
                t = 255;
            end
        end
        last_pix = PW'(t);
        return PW'(t);
    endfunction

    // offer one pixel beat, starting and ending at a falling edge
    task automatic send_pixel(input logic [PW-1:0] pix, input logic known,
                              input logic [PW-1:0] known_val);
        logic [PW-1:0] pred;
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.pixel_in <= pix;
        @(posedge i_clk);
        while (!pix_in.ready) begin
            @(posedge i_clk);
        end
        pred = predict_pixel(pix);
        expected_pix_q.push_back(known ? known_val : pred);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding pixel
    task automatic wait_all_results();
        pix_in.valid <= 1'b0;
        while (expected_pix_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // drain and let the sequencer settle before a register write
    task automatic settle_block();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_shade(input logic [SW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shade_reg    = val;
    endtask

    // output receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            pix_out.ready <= 1'b0;
            hold_left--;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // compare each output beat with the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_pix_q.size() == 0) begin
                $display("%0t: pixel_out beat %0d with nothing expected", $time,
                         pix_out.pixel_out);
                fail_cnt++;
            end else begin
                exp_pix = expected_pix_q.pop_front();
                if (exp_pix !== pix_out.pixel_out) begin
                    $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $time,
                             exp_pix, pix_out.pixel_out);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("weighted_error_queue_dither_unit regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        pix_in.valid    = 1'b0;
        pix_in.pixel_in = '0;
        pix_out.ready   = 1'b0;
        shade_reg       = SW'(wequ_pkg::SHADE_MIN);
        last_pix        = '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            err_hist[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, light idling on both sides
        src_idle_pct  = 6;
        snk_stall_pct = 6;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].cfg_row) begin
                settle_block();
                write_shade(DIR_TAB[r].shade);
            end else begin
                send_pixel(DIR_TAB[r].pix, DIR_TAB[r].known, DIR_TAB[r].pix_exp);
            end
        end

        // random phases, each with its own shade write and one of four idling patterns
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_block();
            case (ph)
                0: write_shade(SW'(2));
                1: write_shade(SW'(256));
                2: write_shade(SW'(0));
                3: write_shade(SW'(511));
                4: write_shade(SW'(257));
                5: write_shade(SW'($urandom_range(255, 3)));
                6: write_shade(SW'(1));
                default: write_shade(SW'($urandom_range(511)));
            endcase
            case (ph % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 87;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 87;
                end
                default: begin
                    src_idle_pct  = 6;
                    snk_stall_pct = 6;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while beats keep coming
                if (ph == 0 && n == 40) begin
                    hold_req = 1'b1;
                end
                // sender pause until the pipeline is empty
                if (ph == 0 && n == 120) begin
                    wait_all_results();
                end
                send_pixel(next_pixel(), 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("weighted_error_queue_dither_unit regression: pass");
        end else begin
            $display("weighted_error_queue_dither_unit regression: fail");
        end
        $finish;
    end

endmodule
